### rtl/nbp_tuple_extractor_defines.svh
// Assertion macros shared by the tuple extractor RTL.
`ifndef NBP_TUPLE_EXTRACTOR_DEFINES_SVH
`define NBP_TUPLE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/nbp_pkg.sv
// Types and constants of the tuple extractor.
package nbp_pkg;

   localparam int STRING_LIMIT_DEF = 32;
   localparam int ADDR_BYTES       = 4;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int POS_W   = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WANTED_ENTRY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT  = 2'd1;

   localparam logic [KIND_W-1:0] KIND_ADDR     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OBJ_LEN  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OBJ_CHR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TYP_LEN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TYP_CHR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ZON_LEN  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ZON_CHR  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd7;

   typedef enum logic [2:0] {
      PH_ADDR    = 3'd0,
      PH_ENUM    = 3'd1,
      PH_OBJ_LEN = 3'd2,
      PH_OBJ_CHR = 3'd3,
      PH_TYP_LEN = 3'd4,
      PH_TYP_CHR = 3'd5,
      PH_ZON_LEN = 3'd6,
      PH_ZON_CHR = 3'd7
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              buffer_start;
   } req_beat_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              last;
   } rsp_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] wanted_entry;
      logic [BYTE_W-1:0] entry_count;
   } cfg_type;

endpackage

### rtl/nbp_scan.sv
// Byte-serial tuple walker: scan state and per-byte result.
`include "nbp_tuple_extractor_defines.svh"

module nbp_scan #(
   parameter int STRING_LIMIT = nbp_pkg::STRING_LIMIT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_valid,
   input  nbp_pkg::req_beat_type req,
   input  nbp_pkg::cfg_type      cfg,
   output logic                res_valid,
   output nbp_pkg::rsp_beat_type res
);
   import nbp_pkg::*;

   localparam int CNT_BITS = $clog2(STRING_LIMIT + 1);
   localparam int CNT_W    = (CNT_BITS > 3) ? CNT_BITS : 3;
   localparam logic [CNT_W-1:0]  LIMIT_CNT  = CNT_W'(STRING_LIMIT);
   localparam logic [BYTE_W-1:0] LIMIT_BYTE = BYTE_W'(STRING_LIMIT);
   localparam logic [CNT_W-1:0]  ADDR_LAST  = CNT_W'(ADDR_BYTES - 1);

   logic [BYTE_W-1:0] tuple_number_ff, tuple_number_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              finished_ff, finished_in;

   // state as seen after an optional restart
   logic [BYTE_W-1:0] tn;
   phase_type         ph;
   logic [BYTE_W-1:0] rem;
   logic [CNT_W-1:0]  cnt;
   logic              fin;

   logic              sel, emit, chr_ok, zone_end;
   logic [CNT_W-1:0]  cnt_a;
   logic [BYTE_W-1:0] rem_a;
   phase_type         chr_target, skip_target;
   logic [KIND_W-1:0] len_kind, chr_kind;
   rsp_beat_type      res_c;

   always_comb begin
      tn  = req.buffer_start ? BYTE_W'(1) : tuple_number_ff;
      ph  = req.buffer_start ? PH_ADDR    : phase_ff;
      rem = req.buffer_start ? '0         : remain_ff;
      cnt = req.buffer_start ? '0         : count_ff;
      fin = req.buffer_start ? 1'b0       : finished_ff;

      tuple_number_in = tn;
      phase_in        = ph;
      remain_in       = rem;
      count_in        = cnt;
      finished_in     = fin;

      sel      = (tn == cfg.wanted_entry);
      emit     = 1'b0;
      chr_ok   = (cnt < LIMIT_CNT);
      cnt_a    = chr_ok ? cnt + CNT_W'(1) : cnt;
      rem_a    = (rem != '0) ? rem - BYTE_W'(1) : '0;
      zone_end = 1'b0;

      case (ph)
         PH_OBJ_LEN, PH_OBJ_CHR: begin
            chr_target  = PH_OBJ_CHR;
            skip_target = PH_TYP_LEN;
            len_kind    = KIND_OBJ_LEN;
            chr_kind    = KIND_OBJ_CHR;
         end
         PH_TYP_LEN, PH_TYP_CHR: begin
            chr_target  = PH_TYP_CHR;
            skip_target = PH_ZON_LEN;
            len_kind    = KIND_TYP_LEN;
            chr_kind    = KIND_TYP_CHR;
         end
         default: begin
            chr_target  = PH_ZON_CHR;
            skip_target = PH_ADDR;
            len_kind    = KIND_ZON_LEN;
            chr_kind    = KIND_ZON_CHR;
         end
      endcase

      res_c.kind     = KIND_ADDR;
      res_c.value    = '0;
      res_c.position = '0;
      res_c.last     = 1'b0;

      if (!fin) begin
         if (tn == BYTE_W'(1) && ph == PH_ADDR && cnt == '0 &&
             (cfg.wanted_entry == '0 || cfg.wanted_entry > cfg.entry_count)) begin
            // bad index: one error beat, then the buffer is ignored
            emit        = 1'b1;
            res_c.kind  = KIND_ERROR;
            res_c.last  = 1'b1;
            finished_in = 1'b1;
         end else begin
            case (ph)
               PH_ADDR: begin
                  emit           = sel;
                  res_c.kind     = KIND_ADDR;
                  res_c.value    = req.data_byte;
                  res_c.position = POS_W'(cnt);
                  if (cnt == ADDR_LAST) begin
                     count_in = '0;
                     phase_in = PH_ENUM;
                  end else begin
                     count_in = cnt + CNT_W'(1);
                  end
               end
               PH_ENUM: begin
                  phase_in = PH_OBJ_LEN;
               end
               PH_OBJ_LEN, PH_TYP_LEN, PH_ZON_LEN: begin
                  emit        = sel;
                  res_c.kind  = len_kind;
                  res_c.value = (req.data_byte > LIMIT_BYTE) ? LIMIT_BYTE : req.data_byte;
                  res_c.last  = (req.data_byte == '0) && (ph == PH_ZON_LEN);
                  remain_in   = req.data_byte;
                  count_in    = '0;
                  if (req.data_byte != '0) begin
                     phase_in = chr_target;
                  end else if (ph != PH_ZON_LEN) begin
                     phase_in = skip_target;
                  end else begin
                     finished_in     = sel;
                     tuple_number_in = tn + BYTE_W'(1);
                     phase_in        = PH_ADDR;
                  end
               end
               PH_OBJ_CHR, PH_TYP_CHR, PH_ZON_CHR: begin
                  emit           = sel && chr_ok;
                  zone_end       = (ph == PH_ZON_CHR) && (cnt_a >= LIMIT_CNT || rem_a == '0);
                  res_c.kind     = chr_kind;
                  res_c.value    = req.data_byte;
                  res_c.position = POS_W'(cnt_a);
                  res_c.last     = zone_end;
                  count_in       = cnt_a;
                  remain_in      = rem_a;
                  if (emit && zone_end) begin
                     finished_in = 1'b1;
                  end else if (rem_a == '0) begin
                     count_in = '0;
                     if (ph != PH_ZON_CHR) begin
                        phase_in = skip_target;
                     end else begin
                        tuple_number_in = tn + BYTE_W'(1);
                        phase_in        = PH_ADDR;
                     end
                  end
               end
               default: begin
                  phase_in  = PH_ADDR;
                  count_in  = '0;
                  remain_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuple_number_ff <= BYTE_W'(1);
         phase_ff        <= PH_ADDR;
         remain_ff       <= '0;
         count_ff        <= '0;
         finished_ff     <= 1'b0;
      end else if (beat_valid) begin
         tuple_number_ff <= tuple_number_in;
         phase_ff        <= phase_in;
         remain_ff       <= remain_in;
         count_ff        <= count_in;
         finished_ff     <= finished_in;
      end
   end

   assign res_valid = beat_valid && emit;
   assign res       = res_c;

   `NBP_ASSERT_NOW(a_quiet_when_done, clock, reset,
      beat_valid && !req.buffer_start && finished_ff, !res_valid,
      "result produced after scan finished")
   `NBP_ASSERT_NEXT(a_last_finishes, clock, reset,
      res_valid && res.last, finished_ff,
      "final beat did not end the scan")
   `NBP_ASSERT_NOW(a_addr_count, clock, reset,
      phase_ff == PH_ADDR, count_ff <= ADDR_LAST,
      "address byte count out of range")

endmodule

### rtl/nbp_rsp_buf.sv
// Two-entry result buffer between the scan logic and the rsp channel.
`include "nbp_tuple_extractor_defines.svh"

module nbp_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  nbp_pkg::rsp_beat_type in_beat,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output nbp_pkg::rsp_beat_type out_beat
);
   import nbp_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type main_ff, main_in;
   rsp_beat_type skid_ff, skid_in;
   logic         main_free;

   always_comb begin
      main_free     = !main_valid_ff || out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = in_valid;
            skid_in       = in_beat;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_beat;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_beat  = main_ff;

   `NBP_ASSERT_NOW(a_no_overflow, clock, reset,
      in_valid, !skid_valid_ff,
      "push into full result buffer")
   `NBP_ASSERT_NOW(a_skid_behind_main, clock, reset,
      skid_valid_ff, main_valid_ff,
      "skid entry held with empty output register")
   `NBP_ASSERT_NEXT(a_skid_moves_up, clock, reset,
      skid_valid_ff && out_ready, main_valid_ff,
      "skid entry lost on pop")

endmodule

### rtl/nbp_tuple_extractor.sv
// Top level of the name-lookup reply tuple extractor.
//
// Takes a reply buffer one byte per req beat and returns the wanted tuple
// (wanted_entry, one-based) as rsp beats: four address bytes, then for the
// object, type and zone strings a clipped length beat followed by up to
// STRING_LIMIT character beats. Other tuples and the enumerator byte give
// no beat. A wanted index of zero or above entry_count gives a single error
// beat on the first byte and the rest of the buffer is dropped until a
// beat with buffer_start set. Throughput is one byte per clock while
// req_ready is high. The per-byte work is a single pass of short logic
// into the result register, and a two-entry output buffer keeps req_ready
// high until two results are stalled on rsp.
// The csr port is always ready; write it only while the block is idle.
`include "nbp_tuple_extractor_defines.svh"

module nbp_tuple_extractor #(
   parameter int STRING_LIMIT = nbp_pkg::STRING_LIMIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nbp_pkg::req_beat_type           req_beat,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nbp_pkg::rsp_beat_type           rsp_beat,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nbp_pkg::BYTE_W-1:0]      csr_wdata
);
   import nbp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         req_accept;
   logic         res_valid;
   rsp_beat_type res;
   logic         buf_space;

   // registers: writes to unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WANTED_ENTRY: cfg_in.wanted_entry = csr_wdata;
            CSR_ENTRY_COUNT:  cfg_in.entry_count  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_entry <= BYTE_W'(1);
         cfg_ff.entry_count  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_ready  = buf_space;
   assign req_accept = req_valid && buf_space;

   // tuple walker: one byte per beat
   nbp_scan #(
      .STRING_LIMIT (STRING_LIMIT)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_accept),
      .req        (req_beat),
      .cfg        (cfg_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register plus skid entry
   nbp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_beat   (res),
      .space     (buf_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (rsp_beat)
   );

endmodule
